// ===== rtl/asbmrd_pkg.sv =====
// Package: operand width, opcodes, pipeline stage word and the per-stage iteration function.
package asbmrd_pkg;

  // Operand and result word width.
  localparam int WIDTH = 8;

  // One load stage followed by one stage per iteration.
  localparam int NSTG = WIDTH + 1;

  // Operation codes.
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Booth recoding pairs {q[0], q[-1]}.
  localparam logic [1:0] BOOTH_SUB = 2'b10;
  localparam logic [1:0] BOOTH_ADD = 2'b01;

  // State of one operation as it travels down the pipeline.
  // For multiply, acc is the accumulator and q the multiplier.
  // For divide, acc is the partial remainder and q the quotient.
  // For add and subtract, q holds the finished result and acc stays zero.
  typedef struct packed {
    cmd_t             cmd;
    logic [WIDTH-1:0] m;
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] q;
    logic             qm1;
  } stage_t;

  // One Booth or restoring-division iteration; add and subtract pass through.
  function automatic stage_t step(stage_t s);
    stage_t           r;
    logic [WIDTH-1:0] sum;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] dif;
    r   = s;
    sum = '0;
    rem = '0;
    dif = '0;
    case (s.cmd)
      CMD_MUL: begin
        case ({s.q[0], s.qm1})
          BOOTH_SUB: sum = s.acc - s.m;
          BOOTH_ADD: sum = s.acc + s.m;
          default:   sum = s.acc;
        endcase
        // Arithmetic right shift of the whole {acc, q, qm1} chain.
        r.qm1 = s.q[0];
        r.q   = {sum[0], s.q[WIDTH-1:1]};
        r.acc = {sum[WIDTH-1], sum[WIDTH-1:1]};
      end
      CMD_DIV: begin
        // Shift the remainder and quotient left together, then trial subtract.
        rem   = {s.acc[WIDTH-2:0], s.q[WIDTH-1]};
        dif   = rem - s.m;
        r.acc = dif[WIDTH-1] ? rem : dif;
        r.q   = {s.q[WIDTH-2:0], ~dif[WIDTH-1]};
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/asbmrd_in_if.sv =====
// Interface: input channel carrying the opcode and both operands.
interface asbmrd_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [asbmrd_pkg::WIDTH-1:0]  operand_a;
  logic [asbmrd_pkg::WIDTH-1:0]  operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

// ===== rtl/asbmrd_out_if.sv =====
// Interface: result channel carrying the high and low result words.
interface asbmrd_out_if;
  logic                          valid;
  logic                          ready;
  logic [asbmrd_pkg::WIDTH-1:0]  result_high;
  logic [asbmrd_pkg::WIDTH-1:0]  result_low;

  modport source (output valid, output result_high, output result_low, input ready);
  modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

// ===== rtl/asbmrd_stage.sv =====
// Module: one pipeline stage that performs a single multiply or divide iteration and passes add and subtract through.
module asbmrd_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  logic               prev_vld,
  input  asbmrd_pkg::stage_t prev_data,
  output logic               vld_r,
  output asbmrd_pkg::stage_t data_r
);

  asbmrd_pkg::stage_t data_nxt;

  // Iteration logic between this stage and the previous one.
  always_comb begin
    data_nxt = asbmrd_pkg::step(prev_data);
  end

  // Valid bit moves whenever the stage may load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= prev_vld;
    end
  end

  // Payload loads only when a word actually arrives.
  always_ff @(posedge clk) begin
    if (ld && prev_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/add_sub_booth_mul_restoring_div.sv =====
// Add, subtract, radix-2 Booth multiply and restoring divide, as a WIDTH+1 stage pipeline
// that takes one word per cycle unless backpressure fills it, and returns each result from the last
// stage register; the depth is set by one load stage followed by one stage per multiply or divide
// iteration, and under backpressure a stage holds only while every stage ahead of it is full.
module add_sub_booth_mul_restoring_div (
  input  logic                clk,
  input  logic                rst_n,
  asbmrd_in_if.sink           in_word,
  asbmrd_out_if.source        out_word
);

  localparam int NSTG = asbmrd_pkg::NSTG;

  asbmrd_pkg::stage_t stg_w [NSTG];
  logic [NSTG-1:0]    vld_w;
  logic [NSTG:0]      rdy_w;
  asbmrd_pkg::stage_t init_nxt;
  asbmrd_pkg::stage_t stg0_r;
  logic               vld0_r;
  asbmrd_pkg::cmd_t   in_cmd;
  asbmrd_pkg::stage_t last_w;

  // Per-stage ready: a stage may load when it is empty or its word moves on.
  always_comb begin
    rdy_w[NSTG] = out_word.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy_w[k] = !vld_w[k] || rdy_w[k+1];
    end
  end

  assign in_word.ready = rdy_w[0];

  // Load stage: set up the iteration state, and finish add and subtract here.
  always_comb begin
    in_cmd       = asbmrd_pkg::cmd_t'(in_word.cmd);
    init_nxt.cmd = in_cmd;
    init_nxt.m   = '0;
    init_nxt.acc = '0;
    init_nxt.q   = '0;
    init_nxt.qm1 = 1'b0;
    case (in_cmd)
      asbmrd_pkg::CMD_ADD: begin
        init_nxt.q = in_word.operand_a + in_word.operand_b;
      end
      asbmrd_pkg::CMD_SUB: begin
        init_nxt.q = in_word.operand_a
                   + (~in_word.operand_b + {{(asbmrd_pkg::WIDTH-1){1'b0}}, 1'b1});
      end
      asbmrd_pkg::CMD_MUL: begin
        init_nxt.m = in_word.operand_a;
        init_nxt.q = in_word.operand_b;
      end
      asbmrd_pkg::CMD_DIV: begin
        init_nxt.m = in_word.operand_b;
        init_nxt.q = in_word.operand_a;
      end
      default: begin
        init_nxt.q = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (rdy_w[0]) begin
      vld0_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_w[0] && in_word.valid) begin
      stg0_r <= init_nxt;
    end
  end

  assign stg_w[0] = stg0_r;
  assign vld_w[0] = vld0_r;

  // Iteration stages, one per multiply or divide step.
  for (genvar g = 1; g < NSTG; g++) begin : g_stage
    asbmrd_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .ld        (rdy_w[g]),
      .prev_vld  (vld_w[g-1]),
      .prev_data (stg_w[g-1]),
      .vld_r     (vld_w[g]),
      .data_r    (stg_w[g])
    );
  end

  // Result words come straight from the last stage register.
  assign last_w               = stg_w[NSTG-1];
  assign out_word.valid       = vld_w[NSTG-1];
  assign out_word.result_high = (last_w.cmd == asbmrd_pkg::CMD_DIV) ? last_w.q : last_w.acc;
  assign out_word.result_low  = (last_w.cmd == asbmrd_pkg::CMD_DIV) ? last_w.acc : last_w.q;

`ifndef ASSERT_OFF
  // An accepted word always lands in the load stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> vld_w[0])
    else $error("accepted word missing from load stage");

  // A word stalled in the load stage keeps its contents.
  a_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_w[0] && !rdy_w[1] |=> vld_w[0] && $stable(stg_w[0]))
    else $error("stalled load stage changed");

  // The opcode travels unchanged into the last stage.
  a_cmd_travels: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_w[NSTG-1] && vld_w[NSTG-2] |=> stg_w[NSTG-1].cmd == $past(stg_w[NSTG-2].cmd))
    else $error("opcode corrupted in last stage");

  // Add and subtract give a zero high word.
  a_addsub_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && (last_w.cmd == asbmrd_pkg::CMD_ADD || last_w.cmd == asbmrd_pkg::CMD_SUB)
    |-> out_word.result_high == '0)
    else $error("nonzero high word for add or subtract");
`endif

endmodule
